// ----- rtl/sgr_pkg.sv -----
// Shared types and constants for the SGR escape sequence parser.
package sgr_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_SEQ  = 2'd2;

  localparam logic [1:0] KIND_PRINT = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  localparam logic [7:0] ESC_BYTE     = 8'd27;
  localparam logic [7:0] LSQUARE_BYTE = 8'h5B;
  localparam logic [7:0] SEMI_BYTE    = 8'h3B;
  localparam logic [7:0] M_BYTE       = 8'h6D;
  localparam logic [7:0] DIGIT_LOW    = 8'h30;
  localparam logic [7:0] DIGIT_HIGH   = 8'h39;
  localparam logic [7:0] FORE_LOW     = 8'd30;
  localparam logic [7:0] FORE_HIGH    = 8'd37;
  localparam logic [7:0] BACK_LOW     = 8'd40;
  localparam logic [7:0] BACK_HIGH    = 8'd47;
  localparam logic [7:0] CODE_RESET   = 8'd0;
  localparam logic [7:0] CODE_BOLD    = 8'd1;
  localparam logic [7:0] CODE_ULINE   = 8'd4;
  localparam logic [7:0] ACCUM_MAX    = 8'd255;

  localparam logic [2:0] FORE_DEFAULT = 3'd7;
  localparam logic [2:0] BACK_DEFAULT = 3'd0;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] accum;
    logic       have_digits;
    logic       bold;
    logic       uline;
    logic [2:0] fore;
    logic [2:0] back;
  } sgr_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] ch;
    logic       bold;
    logic       uline;
    logic [2:0] fore;
    logic [2:0] back;
  } sgr_result_t;

endpackage

// ----- rtl/ansi_sgr_escape_parser.sv -----
// Top level of the ANSI SGR escape sequence parser.
// The parser takes one text byte per cycle when not stalled and sorts plain
// characters from SGR sequences (ESC '[' n ';' n ... 'm'). Each accepted word
// updates the parse state in the same cycle and, when it produces a result,
// loads the single output register; so the sustained rate is one byte per
// clock without stalls; a byte's result is on the output in the next cycle.
// Bytes that produce nothing (ESC, '[', digits, separators) leave the output
// untouched. The input is stalled only while a result sits in the output
// register and the consumer stalls it. result_kind is 0 for a printed
// character (out_char), 1 for a gathered attribute set (bold_on,
// underline_on, fore_colour, back_colour) and 2 for an attribute reset
// (code 0, which also ends the sequence at once). Fields that do not belong
// to the kind read as zero. Parameters saturate at 255; unknown codes are
// ignored, and any unexpected byte inside a sequence is printed and ends it.
// last_of_text returns the parser to idle after its byte.
module ansi_sgr_escape_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       last_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] out_char,
  output logic       bold_on,
  output logic       underline_on,
  output logic [2:0] fore_colour,
  output logic [2:0] back_colour
);
  import sgr_pkg::*;

  sgr_state_t  state;
  sgr_state_t  state_next;
  sgr_result_t result;
  logic        in_accept;

  // hold input only while the output word is full and blocked
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  sgr_step u_step (
    .in_char      (in_char),
    .last_of_text (last_of_text),
    .state        (state),
    .state_next   (state_next),
    .result       (result)
  );

  // parse state: advance on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_IDLE;
      state.accum       <= '0;
      state.have_digits <= 1'b0;
      state.bold        <= 1'b0;
      state.uline       <= 1'b0;
      state.fore        <= FORE_DEFAULT;
      state.back        <= BACK_DEFAULT;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // output register: load a new result, or drop the old one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= result.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && result.valid) begin
      result_kind  <= result.kind;
      out_char     <= result.ch;
      bold_on      <= result.bold;
      underline_on <= result.uline;
      fore_colour  <= result.fore;
      back_colour  <= result.back;
    end
  end

  // end of text always leaves the parser idle with a clear accumulator
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_of_text |=> state.phase == PH_IDLE && state.accum == '0
      && !state.have_digits)
    else $error("parser not idle after end of text");

  // input is only held back by a full, stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // attribute results never carry a character
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_PRINT |-> out_char == '0)
    else $error("character set on attribute result");

  // an ESC accepted from idle opens a sequence and yields nothing
  a_esc_open: assert property (@(posedge clk) disable iff (rst)
    in_accept && state.phase == PH_IDLE && in_char == ESC_BYTE && !last_of_text
      |=> state.phase == PH_ESC && !out_valid)
    else $error("ESC did not open a sequence");

endmodule

// ----- rtl/sgr_step.sv -----
// Per-byte next-state and result logic of the SGR escape sequence parser.
module sgr_step (
  input  logic [7:0]          in_char,
  input  logic                last_of_text,
  input  sgr_pkg::sgr_state_t state,
  output sgr_pkg::sgr_state_t state_next,
  output sgr_pkg::sgr_result_t result
);
  import sgr_pkg::*;

  always_comb begin
    logic        is_digit;
    logic        done;
    logic [11:0] prod;
    logic [7:0]  code;
    logic [7:0]  fore_off;
    logic [7:0]  back_off;

    state_next = state;
    result     = '0;
    done       = 1'b0;
    is_digit   = (in_char >= DIGIT_LOW) && (in_char <= DIGIT_HIGH);
    code       = state.accum;
    fore_off   = code - FORE_LOW;
    back_off   = code - BACK_LOW;
    prod       = {4'd0, state.accum} * 12'd10 + {4'd0, in_char - DIGIT_LOW};

    case (state.phase)
      PH_ESC: begin
        if (in_char == LSQUARE_BYTE) begin
          state_next.bold        = 1'b0;
          state_next.uline       = 1'b0;
          state_next.fore        = FORE_DEFAULT;
          state_next.back        = BACK_DEFAULT;
          state_next.accum       = '0;
          state_next.have_digits = 1'b0;
          state_next.phase       = PH_SEQ;
        end else begin
          result.valid     = 1'b1;
          result.kind      = KIND_PRINT;
          result.ch        = in_char;
          state_next.phase = PH_IDLE;
        end
      end
      PH_SEQ: begin
        // close the current parameter on a separator or the final 'm'
        if ((in_char == SEMI_BYTE || in_char == M_BYTE) && state.have_digits) begin
          state_next.accum       = '0;
          state_next.have_digits = 1'b0;
          if (code == CODE_BOLD) begin
            state_next.bold = 1'b1;
          end else if (code == CODE_ULINE) begin
            state_next.uline = 1'b1;
          end else if (code >= FORE_LOW && code <= FORE_HIGH) begin
            state_next.fore = fore_off[2:0];
          end else if (code >= BACK_LOW && code <= BACK_HIGH) begin
            state_next.back = back_off[2:0];
          end else if (code == CODE_RESET) begin
            result.valid     = 1'b1;
            result.kind      = KIND_RESET;
            state_next.phase = PH_IDLE;
            done             = 1'b1;
          end
        end
        if (!done) begin
          if (in_char == M_BYTE) begin
            result.valid     = 1'b1;
            result.kind      = KIND_SET;
            result.bold      = state_next.bold;
            result.uline     = state_next.uline;
            result.fore      = state_next.fore;
            result.back      = state_next.back;
            state_next.phase = PH_IDLE;
          end else if (is_digit) begin
            state_next.accum       = (prod > {4'd0, ACCUM_MAX}) ? ACCUM_MAX : prod[7:0];
            state_next.have_digits = 1'b1;
          end else if (in_char != SEMI_BYTE) begin
            result.valid     = 1'b1;
            result.kind      = KIND_PRINT;
            result.ch        = in_char;
            state_next.phase = PH_IDLE;
          end
        end
      end
      default: begin
        if (in_char == ESC_BYTE) begin
          state_next.phase = PH_ESC;
        end else begin
          result.valid     = 1'b1;
          result.kind      = KIND_PRINT;
          result.ch        = in_char;
          state_next.phase = PH_IDLE;
        end
      end
    endcase

    if (last_of_text) begin
      state_next.phase       = PH_IDLE;
      state_next.accum       = '0;
      state_next.have_digits = 1'b0;
    end
  end

endmodule
